[rtl/i2cm_pkg.sv]
// Shared types, codes and helpers for the I2C master bit engine.
package i2cm_pkg;

    // Command codes carried with each tick
    localparam logic [2:0] FN_NONE  = 3'd0;
    localparam logic [2:0] FN_START = 3'd1;
    localparam logic [2:0] FN_STOP  = 3'd2;
    localparam logic [2:0] FN_SEND  = 3'd3;
    localparam logic [2:0] FN_READ  = 3'd4;
    localparam logic [2:0] FN_WACK  = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] REG_START_STOP = 2'd0;
    localparam logic [1:0] REG_BIT_PHASE  = 2'd1;
    localparam logic [1:0] REG_ACK_TMO    = 2'd2;

    // Configuration reset values
    localparam logic [7:0] START_STOP_RST = 8'd4;
    localparam logic [7:0] BIT_PHASE_RST  = 8'd2;
    localparam logic [7:0] ACK_TMO_RST    = 8'd250;

    localparam int unsigned DATA_BITS = 8;

    typedef enum logic [3:0] {
        PH_IDLE, PH_ST_HI, PH_ST_LO, PH_SP_LO, PH_SP_HI,
        PH_TX_LO, PH_TX_HI, PH_TX_TAIL, PH_RX_LO, PH_RX_HI,
        PH_AK_LO, PH_AK_HI, PH_WA_REL, PH_WA_HI, PH_WA_POLL
    } phase_t;

    // Sequencer state
    typedef struct packed {
        phase_t     phase;
        logic [7:0] tick_count;
        logic [3:0] bit_index;
        logic [7:0] shift_reg;
        logic [7:0] poll_count;
        logic       scl;
        logic       sda;
        logic       sda_en;
        logic       ack_mode;
        logic       fail_flag;
        logic [7:0] rx_hold;
    } st_t;

    // Timing configuration
    typedef struct packed {
        logic [7:0] start_stop_ticks;
        logic [7:0] bit_phase_ticks;
        logic [7:0] ack_timeout_ticks;
    } cfg_t;

    // A zero length counts as one tick
    function automatic logic [7:0] at_least_one(input logic [7:0] v);
        at_least_one = (v == 8'd0) ? 8'd1 : v;
    endfunction

endpackage

[rtl/i2cm_step.sv]
// One-tick state update of the I2C bus sequencer.
module i2cm_step (
    input  i2cm_pkg::st_t  cur,
    input  i2cm_pkg::cfg_t cfg,
    input  logic [2:0]     func,
    input  logic [7:0]     tx_byte,
    input  logic           reply_ack,
    input  logic           sda_in,
    output i2cm_pkg::st_t  nxt,
    output logic           done
);
    import i2cm_pkg::*;

    logic [7:0] ss_len;
    logic [7:0] bp_len;
    logic [7:0] tmo_len;
    logic [7:0] tc_dec;
    logic [3:0] bi_inc;
    logic [7:0] sr_shl;

    assign ss_len  = at_least_one(cfg.start_stop_ticks);
    assign bp_len  = at_least_one(cfg.bit_phase_ticks);
    assign tmo_len = at_least_one(cfg.ack_timeout_ticks);
    assign tc_dec  = (cur.tick_count != 8'd0) ? cur.tick_count - 8'd1 : 8'd0;
    assign bi_inc  = cur.bit_index + 4'd1;
    assign sr_shl  = {cur.shift_reg[6:0], 1'b0};

    // Command decode, ack polling and phase timer
    always_comb begin
        nxt  = cur;
        done = 1'b0;
        case (cur.phase)
            PH_IDLE: begin
                case (func)
                    FN_START: begin
                        nxt.scl = 1'b1; nxt.sda = 1'b1; nxt.sda_en = 1'b1;
                        nxt.phase = PH_ST_HI; nxt.tick_count = ss_len;
                    end
                    FN_STOP: begin
                        nxt.scl = 1'b0; nxt.sda = 1'b0; nxt.sda_en = 1'b1;
                        nxt.phase = PH_SP_LO; nxt.tick_count = ss_len;
                    end
                    FN_SEND: begin
                        nxt.shift_reg = tx_byte; nxt.bit_index = 4'd0;
                        nxt.scl = 1'b0; nxt.sda_en = 1'b1; nxt.sda = tx_byte[7];
                        nxt.phase = PH_TX_LO; nxt.tick_count = bp_len;
                    end
                    FN_READ: begin
                        nxt.ack_mode = reply_ack; nxt.shift_reg = 8'd0;
                        nxt.bit_index = 4'd0;
                        nxt.scl = 1'b0; nxt.sda = 1'b1; nxt.sda_en = 1'b0;
                        nxt.phase = PH_RX_LO; nxt.tick_count = bp_len;
                    end
                    FN_WACK: begin
                        nxt.fail_flag = 1'b0; nxt.poll_count = 8'd0;
                        nxt.sda = 1'b1; nxt.sda_en = 1'b0;
                        nxt.phase = PH_WA_REL; nxt.tick_count = 8'd1;
                    end
                    default: ;
                endcase
            end
            PH_WA_POLL: begin
                if (!sda_in) begin
                    nxt.scl = 1'b0; nxt.phase = PH_IDLE; done = 1'b1;
                end else if (cur.poll_count >= tmo_len) begin
                    // timeout: flag it and issue a stop
                    nxt.fail_flag = 1'b1;
                    nxt.scl = 1'b0; nxt.sda = 1'b0; nxt.sda_en = 1'b1;
                    nxt.phase = PH_SP_LO; nxt.tick_count = ss_len;
                end else begin
                    nxt.poll_count = cur.poll_count + 8'd1;
                end
            end
            default: begin
                nxt.tick_count = tc_dec;
                if (tc_dec == 8'd0) begin
                    case (cur.phase)
                        PH_ST_HI: begin
                            nxt.sda = 1'b0; nxt.phase = PH_ST_LO; nxt.tick_count = ss_len;
                        end
                        PH_ST_LO: begin
                            nxt.scl = 1'b0; nxt.phase = PH_IDLE; done = 1'b1;
                        end
                        PH_SP_LO: begin
                            nxt.scl = 1'b1; nxt.phase = PH_SP_HI; nxt.tick_count = ss_len;
                        end
                        PH_SP_HI: begin
                            nxt.sda = 1'b1; nxt.phase = PH_IDLE; done = 1'b1;
                        end
                        PH_TX_LO: begin
                            nxt.scl = 1'b1; nxt.phase = PH_TX_HI; nxt.tick_count = bp_len;
                        end
                        PH_TX_HI: begin
                            nxt.scl = 1'b0; nxt.phase = PH_TX_TAIL; nxt.tick_count = bp_len;
                        end
                        PH_TX_TAIL: begin
                            nxt.shift_reg = sr_shl;
                            nxt.bit_index = bi_inc;
                            if (bi_inc >= 4'(DATA_BITS)) begin
                                nxt.phase = PH_IDLE; done = 1'b1;
                            end else begin
                                nxt.sda = sr_shl[7];
                                nxt.phase = PH_TX_LO; nxt.tick_count = bp_len;
                            end
                        end
                        PH_RX_LO: begin
                            // sample on the rising SCL edge
                            nxt.scl = 1'b1;
                            nxt.shift_reg = {cur.shift_reg[6:0], sda_in};
                            nxt.bit_index = bi_inc;
                            nxt.phase = PH_RX_HI; nxt.tick_count = bp_len;
                        end
                        PH_RX_HI: begin
                            nxt.scl = 1'b0;
                            if (cur.bit_index >= 4'(DATA_BITS)) begin
                                nxt.rx_hold = cur.shift_reg;
                                nxt.sda_en = 1'b1; nxt.sda = !cur.ack_mode;
                                nxt.phase = PH_AK_LO;
                            end else begin
                                nxt.phase = PH_RX_LO;
                            end
                            nxt.tick_count = bp_len;
                        end
                        PH_AK_LO: begin
                            nxt.scl = 1'b1; nxt.phase = PH_AK_HI; nxt.tick_count = bp_len;
                        end
                        PH_AK_HI: begin
                            nxt.scl = 1'b0; nxt.phase = PH_IDLE; done = 1'b1;
                        end
                        PH_WA_REL: begin
                            nxt.scl = 1'b1; nxt.phase = PH_WA_HI; nxt.tick_count = 8'd1;
                        end
                        PH_WA_HI: begin
                            nxt.phase = PH_WA_POLL; nxt.tick_count = 8'd0;
                        end
                        default: begin
                            nxt.phase = PH_IDLE;
                        end
                    endcase
                end
            end
        endcase
    end

endmodule

[rtl/i2c_master_bit_engine.sv]
// Top level of the I2C master bit engine: state, configuration and result register.
//
// Each input request is one timebase tick (about 1 us). It carries an optional
// command (s_func) plus the sampled SDA level. Commands are ignored while a
// command is still in progress. Every accepted request produces exactly one
// result request with the driven SCL/SDA levels, the SDA drive enable and
// status (busy, done pulse, last received byte, ack failure).
// The result is registered onto m_* in the cycle after the input is accepted.
// Throughput: one request per cycle without back-pressure; the sequencer update
// is a single pass of logic between the state registers and the result register.
// The result register frees as it is taken, so s_ready stays high while the
// receiver keeps up; when m_ready is low with a result pending, s_ready drops
// and the sequencer holds its state until the result is taken.
// The user must write timing registers (cfg_wr_en/cfg_index/cfg_data) only while
// the engine is idle; the block does not enforce this. Index 3 is ignored.
// Reset (aresetn low, synchronous) returns to idle with SCL and SDA high and
// driven, clears status, restores the timing defaults and drops m_valid.
module i2c_master_bit_engine (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_func,
    input  logic [7:0] s_tx_byte,
    input  logic       s_reply_ack,
    input  logic       s_sda_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_scl_out,
    output logic       m_sda_out,
    output logic       m_sda_drive,
    output logic       m_busy_res,
    output logic       m_done_res,
    output logic [7:0] m_rx_data,
    output logic       m_ack_failed,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import i2cm_pkg::*;

    st_t  st_reg;
    st_t  st_next;
    cfg_t cfg_reg;
    logic done_next;
    logic s_fire;
    logic m_valid_reg;
    logic scl_reg, sda_reg, drive_reg, busy_reg, done_reg, fail_reg;
    logic [7:0] rx_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    i2cm_step u_step (
        .cur       (st_reg),
        .cfg       (cfg_reg),
        .func      (s_func),
        .tx_byte   (s_tx_byte),
        .reply_ack (s_reply_ack),
        .sda_in    (s_sda_in),
        .nxt       (st_next),
        .done      (done_next)
    );

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_stop_ticks  <= START_STOP_RST;
            cfg_reg.bit_phase_ticks   <= BIT_PHASE_RST;
            cfg_reg.ack_timeout_ticks <= ACK_TMO_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_START_STOP: cfg_reg.start_stop_ticks  <= cfg_data;
                REG_BIT_PHASE:  cfg_reg.bit_phase_ticks   <= cfg_data;
                REG_ACK_TMO:    cfg_reg.ack_timeout_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer state advances once per accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.phase      <= PH_IDLE;
            st_reg.tick_count <= 8'd0;
            st_reg.bit_index  <= 4'd0;
            st_reg.shift_reg  <= 8'd0;
            st_reg.poll_count <= 8'd0;
            st_reg.scl        <= 1'b1;
            st_reg.sda        <= 1'b1;
            st_reg.sda_en     <= 1'b1;
            st_reg.ack_mode   <= 1'b0;
            st_reg.fail_flag  <= 1'b0;
            st_reg.rx_hold    <= 8'd0;
        end else if (s_fire) begin
            st_reg <= st_next;
        end
    end

    // Result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            scl_reg   <= st_next.scl;
            sda_reg   <= st_next.sda;
            drive_reg <= st_next.sda_en;
            busy_reg  <= (st_next.phase != PH_IDLE);
            done_reg  <= done_next;
            rx_reg    <= st_next.rx_hold;
            fail_reg  <= st_next.fail_flag;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_scl_out    = scl_reg;
    assign m_sda_out    = sda_reg;
    assign m_sda_drive  = drive_reg;
    assign m_busy_res   = busy_reg;
    assign m_done_res   = done_reg;
    assign m_rx_data    = rx_reg;
    assign m_ack_failed = fail_reg;

`ifndef SYNTH
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_done_res && m_busy_res))
        else $error("done pulse reported while still busy");

    a_bit_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.bit_index <= 4'(DATA_BITS))
        else $error("bit index beyond byte length");

    a_idle_no_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && st_reg.phase == PH_IDLE && s_func == FN_NONE)
        |=> st_reg.phase == PH_IDLE)
        else $error("engine left idle without a command");

    a_stall_only_on_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without pending result");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |=> $stable(st_reg))
        else $error("sequencer state moved without a request");
`endif

endmodule
